// File: src/manchester_fsk_tone_generator_macros.svh
// Assertion macros shared by the tone generator modules.
`ifndef MANCHESTER_FSK_TONE_GENERATOR_MACROS_SVH
`define MANCHESTER_FSK_TONE_GENERATOR_MACROS_SVH

// Property checked on every rising edge of clk, off while rst is high.
`define MFSKTG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Implication form of the check above.
`define MFSKTG_ASSERT_IMPLY(label, ante, cons, msg) \
  `MFSKTG_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: src/mfsktg_pkg.sv
// Package: types, constants and the sine magnitude table of the tone generator.
`timescale 1ns / 1ps
package mfsktg_pkg;

  localparam int DEF_SAMPLES_PER_MS = 441;
  localparam int HALF_MS_MAX        = 255;
  localparam int HALF_MS_RESET      = 5;
  localparam int HALF_MS_W          = 8;

  localparam int TONE_PERIOD = 441;
  localparam int TONE_HALF   = TONE_PERIOD / 2;
  localparam int TONE_A_STEP = 11;
  localparam int TONE_B_STEP = 22;
  localparam int AMPLITUDE   = 28784;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  localparam int PHASE_W       = $clog2(TONE_PERIOD);
  localparam int MAG_ENTRIES   = TONE_HALF + 1;
  localparam int MAG_IDX_W     = $clog2(MAG_ENTRIES);
  localparam int MAG_W         = 15;
  localparam int SAMPLE_W      = 16;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);

  localparam logic [PHASE_W-1:0] PERIOD_P = PHASE_W'(TONE_PERIOD);
  localparam logic [PHASE_W-1:0] HALF_P   = PHASE_W'(TONE_HALF);
  localparam logic [PHASE_W-1:0] STEP_A_P = PHASE_W'(TONE_A_STEP);
  localparam logic [PHASE_W-1:0] STEP_B_P = PHASE_W'(TONE_B_STEP);

  // input operation codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_HALF_BIT_MS = '0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified transaction on its way from front to back
  typedef struct packed {
    logic [MAG_IDX_W-1:0] mag_idx;
    logic                 neg;
    logic                 busy;
    logic                 last;
    logic                 rejected;
  } entry_t;

  typedef logic [MAG_ENTRIES-1:0][MAG_W-1:0] mag_rom_t;

  // (a * b) >> 60 in Q60
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // trunc(sin(pi * m / 441) * AMPLITUDE) by a Taylor series in Q60
  function automatic logic [MAG_W-1:0] sine_mag(input logic [MAG_IDX_W-1:0] m);
    logic [63:0] q, r, x, x2, term, sum, sh, sl, v;
    q    = PI_Q60 / TONE_PERIOD;
    r    = PI_Q60 % TONE_PERIOD;
    x    = q * 64'(m) + (r * 64'(m)) / TONE_PERIOD;
    x2   = q60_mul(x, x);
    term = x;
    sum  = x;
    term = q60_mul(term, x2) / 64'd6;   sum = sum - term;
    term = q60_mul(term, x2) / 64'd20;  sum = sum + term;
    term = q60_mul(term, x2) / 64'd42;  sum = sum - term;
    term = q60_mul(term, x2) / 64'd72;  sum = sum + term;
    term = q60_mul(term, x2) / 64'd110; sum = sum - term;
    term = q60_mul(term, x2) / 64'd156; sum = sum + term;
    term = q60_mul(term, x2) / 64'd210; sum = sum - term;
    term = q60_mul(term, x2) / 64'd272; sum = sum + term;
    term = q60_mul(term, x2) / 64'd342; sum = sum - term;
    term = q60_mul(term, x2) / 64'd420; sum = sum + term;
    term = q60_mul(term, x2) / 64'd506; sum = sum - term;
    term = q60_mul(term, x2) / 64'd600; sum = sum + term;
    term = q60_mul(term, x2) / 64'd702; sum = sum - term;
    term = q60_mul(term, x2) / 64'd812; sum = sum + term;
    term = q60_mul(term, x2) / 64'd930; sum = sum - term;
    sh = sum >> 30;
    sl = sum & 64'h3FFFFFFF;
    v  = (sh * 64'(AMPLITUDE) + ((sl * 64'(AMPLITUDE)) >> 30)) >> 30;
    return v[MAG_W-1:0];
  endfunction

  function automatic mag_rom_t build_mag_rom();
    mag_rom_t rom;
    for (int i = 0; i < MAG_ENTRIES; i++) begin
      rom[i] = sine_mag(MAG_IDX_W'(i));
    end
    return rom;
  endfunction

  localparam mag_rom_t MAG_ROM = build_mag_rom();

endpackage

// File: src/mfsktg_ifs.sv
// Handshake interfaces for the input and result channels.
`timescale 1ns / 1ps

interface mfsktg_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_value;

  modport source(output valid, func, byte_value, input ready);
  modport sink(input valid, func, byte_value, output ready);
endinterface

interface mfsktg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               busy_res;
  logic               last_of_byte;
  logic               rejected;

  modport source(output valid, sample, busy_res, last_of_byte, rejected, input ready);
  modport sink(input valid, sample, busy_res, last_of_byte, rejected, output ready);
endinterface

// File: src/mfsktg_front.sv
// Front end: accepts transactions, runs the Manchester bit/half/phase sequencer.
`timescale 1ns / 1ps
`include "manchester_fsk_tone_generator_macros.svh"

module mfsktg_front import mfsktg_pkg::*; #(
  parameter int SAMPLES_PER_MS = DEF_SAMPLES_PER_MS,
  localparam int LEN_W = $clog2(HALF_MS_MAX * SAMPLES_PER_MS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  mfsktg_in_if.sink        items,
  input  logic [LEN_W-1:0] half_len,
  output logic             push_valid,
  input  logic             push_ready,
  output entry_t           push_entry
);

  logic [7:0]           shift_byte, shift_byte_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic                 second_half, second_half_next;
  logic [LEN_W-1:0]     sample_count, sample_count_next;
  logic [PHASE_W-1:0]   phase, phase_next;
  logic                 active, active_next;

  logic                 fire;
  logic                 cur_bit;
  logic [PHASE_W-1:0]   step;
  logic [PHASE_W-1:0]   phase_sum;
  logic [PHASE_W-1:0]   phase_adv;
  logic [LEN_W-1:0]     count_inc;
  logic [MAG_IDX_W-1:0] fold_j;
  logic [PHASE_W-1:0]   fold_m2;
  logic [PHASE_W-1:0]   fold_m;

  assign push_valid  = items.valid;
  assign items.ready = push_ready;
  assign fire        = items.valid && push_ready;

  // fold the phase onto the quarter-wave magnitude table
  always_comb begin
    fold_j  = (phase <= HALF_P) ? phase[MAG_IDX_W-1:0]
                                : MAG_IDX_W'(PERIOD_P - phase);
    fold_m2 = {fold_j, 1'b0};
    fold_m  = (fold_m2 > HALF_P) ? PERIOD_P - fold_m2 : fold_m2;
  end

  always_comb begin
    cur_bit   = shift_byte[bit_index];
    // tone A in the first half of a one and in the second half of a zero
    step      = (cur_bit ^ second_half) ? STEP_A_P : STEP_B_P;
    phase_sum = phase + step;
    phase_adv = (phase_sum >= PERIOD_P) ? phase_sum - PERIOD_P : phase_sum;
    count_inc = sample_count + LEN_W'(1);

    shift_byte_next   = shift_byte;
    bit_index_next    = bit_index;
    second_half_next  = second_half;
    sample_count_next = sample_count;
    phase_next        = phase;
    active_next       = active;
    push_entry        = '0;

    if (items.func == FUNC_LOAD) begin
      if (active) begin
        push_entry.rejected = 1'b1;
      end else begin
        shift_byte_next   = items.byte_value;
        bit_index_next    = '0;
        second_half_next  = 1'b0;
        sample_count_next = '0;
        phase_next        = '0;
        active_next       = 1'b1;
      end
    end else if (active) begin
      push_entry.mag_idx = fold_m[MAG_IDX_W-1:0];
      push_entry.neg     = (phase > HALF_P);
      if (count_inc >= half_len) begin
        sample_count_next = '0;
        phase_next        = '0;
        if (second_half) begin
          second_half_next = 1'b0;
          if (bit_index == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
            bit_index_next  = '0;
            active_next     = 1'b0;
            push_entry.last = 1'b1;
          end else begin
            bit_index_next = bit_index + BIT_IDX_W'(1);
          end
        end else begin
          second_half_next = 1'b1;
        end
      end else begin
        sample_count_next = count_inc;
        phase_next        = phase_adv;
      end
    end
    push_entry.busy = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte   <= '0;
      bit_index    <= '0;
      second_half  <= 1'b0;
      sample_count <= '0;
      phase        <= '0;
      active       <= 1'b0;
    end else if (fire) begin
      shift_byte   <= shift_byte_next;
      bit_index    <= bit_index_next;
      second_half  <= second_half_next;
      sample_count <= sample_count_next;
      phase        <= phase_next;
      active       <= active_next;
    end
  end

  `MFSKTG_ASSERT_IMPLY(a_idle_only_after_last, !$past(rst) && $fell(active), $past(fire && push_entry.last), "byte ended without a last-sample transaction")

endmodule

// File: src/mfsktg_queue.sv
// Two-entry queue between the sequencer and the sample stage.
`timescale 1ns / 1ps
`include "manchester_fsk_tone_generator_macros.svh"

module mfsktg_queue import mfsktg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `MFSKTG_ASSERT(a_count_in_range, count <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
  `MFSKTG_ASSERT(a_ptrs_match_count, QPTR_W'(wr_ptr - rd_ptr) == count[QPTR_W-1:0], "queue pointers disagree with count")

endmodule

// File: src/mfsktg_back.sv
// Back end: sine table lookup and the registered result stage.
`timescale 1ns / 1ps
`include "manchester_fsk_tone_generator_macros.svh"

module mfsktg_back import mfsktg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  entry_t      pop_entry,
  mfsktg_out_if.source results
);

  logic                       valid;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       busy_res;
  logic                       last_of_byte;
  logic                       rejected;
  logic signed [SAMPLE_W-1:0] mag_s;
  logic                       pop;

  assign pop_ready = !valid || results.ready;
  assign pop       = pop_valid && pop_ready;
  assign mag_s     = SAMPLE_W'(MAG_ROM[pop_entry.mag_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop_ready) begin
      valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sample       <= pop_entry.neg ? -mag_s : mag_s;
      busy_res     <= pop_entry.busy;
      last_of_byte <= pop_entry.last;
      rejected     <= pop_entry.rejected;
    end
  end

  assign results.valid        = valid;
  assign results.sample       = sample;
  assign results.busy_res     = busy_res;
  assign results.last_of_byte = last_of_byte;
  assign results.rejected     = rejected;

  `MFSKTG_ASSERT_IMPLY(a_last_goes_idle, valid && last_of_byte, !busy_res && !rejected, "last sample flagged while still busy")
  `MFSKTG_ASSERT_IMPLY(a_reject_is_silent, valid && rejected, busy_res && sample == '0, "rejected load carried a sample or idle flag")

endmodule

// File: src/manchester_fsk_tone_generator.sv
// Top level: Manchester-coded two-tone sample generator with APB configuration.
//
// items (sink): func selects load (store byte_value and start sending it) or tick
// (ask for the next sample). results (source): one transaction per input
// transaction, carrying sample, busy_res, last_of_byte and rejected.
// A loaded byte goes out LSB first, each bit as two half-bits of
// half_bit_ms * SAMPLES_PER_MS samples; a load while busy is flagged rejected.
// The APB register half_bit_ms lies at address 0; write it only while idle.
// Throughput: one transaction per cycle while results takes them, as the front
// sequencer updates its phase and counter for every accepted transaction.
// Latency: an accepted transaction is registered in a queue slot and then in
// the table lookup result register before results shows it.
// Reset: the block is idle with half_bit_ms = 5, queue and result stage empty.
// When results stalls, the result register and the two-entry queue fill and
// items.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module manchester_fsk_tone_generator import mfsktg_pkg::*; #(
  parameter int SAMPLES_PER_MS = DEF_SAMPLES_PER_MS
) (
  input  logic                  clk,
  input  logic                  rst,
  mfsktg_in_if.sink             items,
  mfsktg_out_if.source          results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int LEN_W = $clog2(HALF_MS_MAX * SAMPLES_PER_MS + 1);

  logic [HALF_MS_W-1:0] half_bit_ms;
  logic [LEN_W-1:0]     half_len;
  logic [HALF_MS_W-1:0] ms_eff;
  logic                 cfg_write;
  logic                 reg_hit;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[APB_ADDR_W-1:2] == REG_HALF_BIT_MS);
  assign cfg_write = psel && penable && pwrite && reg_hit;
  // zero length counts as one millisecond
  assign ms_eff    = (pwdata[HALF_MS_W-1:0] == '0) ? HALF_MS_W'(1) : pwdata[HALF_MS_W-1:0];
  assign prdata    = reg_hit ? APB_DATA_W'(half_bit_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ms <= HALF_MS_W'(HALF_MS_RESET);
      half_len    <= LEN_W'(HALF_MS_RESET * SAMPLES_PER_MS);
    end else if (cfg_write) begin
      half_bit_ms <= pwdata[HALF_MS_W-1:0];
      half_len    <= LEN_W'(ms_eff) * LEN_W'(SAMPLES_PER_MS);
    end
  end

  mfsktg_front #(
    .SAMPLES_PER_MS(SAMPLES_PER_MS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .half_len  (half_len),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry)
  );

  mfsktg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry)
  );

  mfsktg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_entry(pop_entry),
    .results  (results)
  );

endmodule
